@@ src/dimension_arrow_direction_core_assert.svh @@
// ----------------------------------------------------------------------------
// dimension arrow direction assertion macros
// concurrent assertion helpers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef DIMENSION_ARROW_DIRECTION_CORE_ASSERT_SVH
`define DIMENSION_ARROW_DIRECTION_CORE_ASSERT_SVH

`ifndef SYNTH
`define DAD_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define DAD_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("assertion failed");
`else
`define DAD_ASSERT(lbl, clk, rst, prop)
`define DAD_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ src/dad_pkg.sv @@
// ----------------------------------------------------------------------------
// dad_pkg
// shared types, codes and constants of the arrow direction pipeline
// ----------------------------------------------------------------------------
package dad_pkg;

   localparam int RootBits = 15;
   localparam int AccBits  = 98;
   localparam int L2Bits   = 63;

   localparam logic [1:0] CODE_ABSENT  = 2'd0;
   localparam logic [1:0] CODE_OUTWARD = 2'd1;
   localparam logic [1:0] CODE_INWARD  = 2'd2;
   localparam logic [1:0] CODE_INVALID = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_CODE = 2'd1;
   localparam logic [1:0] ST_ZERO_LEN = 2'd2;

   typedef struct packed {
      logic [1:0] status;
      logic       v1;
      logic       v2;
      logic       n1x;
      logic       n1y;
      logic       n2x;
      logic       n2y;
   } side_type;

   typedef struct packed {
      logic signed [AccBits-1:0] p;
      logic signed [AccBits-1:0] q;
      logic signed [AccBits-1:0] rhs;
      logic [RootBits-1:0]       r;
   } root_type;

   typedef struct packed {
      side_type          side;
      logic [L2Bits-1:0] l2;
      root_type          rx;
      root_type          ry;
   } stage_type;

   function automatic logic [31:0] mag33(input logic signed [32:0] v);
      logic [32:0] n;
      n = -v;
      mag33 = v[32] ? n[31:0] : v[31:0];
   endfunction

endpackage

@@ src/dad_prep.sv @@
// ----------------------------------------------------------------------------
// dad_prep
// four front stages: differences, squares, sums, nearer arrow and root setup
// ----------------------------------------------------------------------------
module dad_prep (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  logic                in_valid,
   input  logic signed [31:0]  sx,
   input  logic signed [31:0]  sy,
   input  logic signed [31:0]  ex,
   input  logic signed [31:0]  ey,
   input  logic signed [31:0]  p1x,
   input  logic signed [31:0]  p1y,
   input  logic signed [31:0]  p2x,
   input  logic signed [31:0]  p2y,
   input  logic [1:0]          c1,
   input  logic [1:0]          c2,
   output logic                out_valid,
   output dad_pkg::stage_type  out_stage
);
   import dad_pkg::*;

   logic signed [32:0] dx, dy, d1x, d1y, d2x, d2y;
   logic [31:0]        mx_raw, my_raw;
   logic               big;
   logic [1:0]         st_in;
   logic               ok_in;

   // stage 1
   logic        s1_v_ff;
   logic [30:0] mx_ff, my_ff;
   logic        sgx_ff, sgy_ff, both_ff, v1_ff, v2_ff;
   logic [1:0]  st_ff, c1_ff, c2_ff;
   logic [31:0] a1x_ff, a1y_ff, a2x_ff, a2y_ff;
   // stage 2
   logic        s2_v_ff;
   logic [61:0] sqx_ff, sqy_ff;
   logic [63:0] q1x_ff, q1y_ff, q2x_ff, q2y_ff;
   logic        s2_sgx_ff, s2_sgy_ff, s2_both_ff, s2_v1_ff, s2_v2_ff;
   logic [1:0]  s2_st_ff, s2_c1_ff, s2_c2_ff;
   // stage 3
   logic        s3_v_ff;
   logic [L2Bits-1:0] l2_ff;
   logic [91:0] rx_ff, ry_ff;
   logic [64:0] e1_ff, e2_ff;
   logic        s3_sgx_ff, s3_sgy_ff, s3_both_ff, s3_v1_ff, s3_v2_ff;
   logic [1:0]  s3_st_ff, s3_c1_ff, s3_c2_ff;
   // stage 4
   logic        near1, neg1, neg2;
   logic        s4_v_ff;
   stage_type   s4_ff, s4_in;

   always_comb begin
      dx  = {ex[31], ex} - {sx[31], sx};
      dy  = {ey[31], ey} - {sy[31], sy};
      d1x = {p1x[31], p1x} - {sx[31], sx};
      d1y = {p1y[31], p1y} - {sy[31], sy};
      d2x = {p2x[31], p2x} - {sx[31], sx};
      d2y = {p2y[31], p2y} - {sy[31], sy};
      mx_raw = mag33(dx);
      my_raw = mag33(dy);
      big = mx_raw[31] | my_raw[31];
      ok_in = 1'b0;
      if (c1 == CODE_INVALID || c2 == CODE_INVALID) begin
         st_in = ST_BAD_CODE;
      end else if (c1 == CODE_ABSENT && c2 == CODE_ABSENT) begin
         st_in = ST_OK;
      end else if (dx == '0 && dy == '0) begin
         st_in = ST_ZERO_LEN;
      end else begin
         st_in = ST_OK;
         ok_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= in_valid;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mx_ff   <= big ? mx_raw[31:1] : mx_raw[30:0];
         my_ff   <= big ? my_raw[31:1] : my_raw[30:0];
         sgx_ff  <= dx[32];
         sgy_ff  <= dy[32];
         both_ff <= (c1 != CODE_ABSENT) && (c2 != CODE_ABSENT);
         v1_ff   <= ok_in && (c1 != CODE_ABSENT);
         v2_ff   <= ok_in && (c2 != CODE_ABSENT);
         st_ff   <= st_in;
         c1_ff   <= c1;
         c2_ff   <= c2;
         a1x_ff  <= mag33(d1x);
         a1y_ff  <= mag33(d1y);
         a2x_ff  <= mag33(d2x);
         a2y_ff  <= mag33(d2y);

         sqx_ff <= 62'(mx_ff * mx_ff);
         sqy_ff <= 62'(my_ff * my_ff);
         q1x_ff <= 64'(a1x_ff * a1x_ff);
         q1y_ff <= 64'(a1y_ff * a1y_ff);
         q2x_ff <= 64'(a2x_ff * a2x_ff);
         q2y_ff <= 64'(a2y_ff * a2y_ff);
         s2_sgx_ff <= sgx_ff;
         s2_sgy_ff <= sgy_ff;
         s2_both_ff <= both_ff;
         s2_v1_ff <= v1_ff;
         s2_v2_ff <= v2_ff;
         s2_st_ff <= st_ff;
         s2_c1_ff <= c1_ff;
         s2_c2_ff <= c2_ff;

         l2_ff <= {1'b0, sqx_ff} + {1'b0, sqy_ff};
         rx_ff <= {sqx_ff, 30'd0};
         ry_ff <= {sqy_ff, 30'd0};
         e1_ff <= {1'b0, q1x_ff} + {1'b0, q1y_ff};
         e2_ff <= {1'b0, q2x_ff} + {1'b0, q2y_ff};
         s3_sgx_ff <= s2_sgx_ff;
         s3_sgy_ff <= s2_sgy_ff;
         s3_both_ff <= s2_both_ff;
         s3_v1_ff <= s2_v1_ff;
         s3_v2_ff <= s2_v2_ff;
         s3_st_ff <= s2_st_ff;
         s3_c1_ff <= s2_c1_ff;
         s3_c2_ff <= s2_c2_ff;

         s4_ff <= s4_in;
      end
   end

   // near arrow: inward along the line, far arrow the other way
   always_comb begin
      near1 = s3_both_ff ? (e1_ff <= e2_ff) : 1'b1;
      neg1  = near1 ? (s3_c1_ff == CODE_OUTWARD) : (s3_c1_ff == CODE_INWARD);
      neg2  = near1 ? (s3_c2_ff == CODE_INWARD) : (s3_c2_ff == CODE_OUTWARD);
      s4_in.side.status = s3_st_ff;
      s4_in.side.v1  = s3_v1_ff;
      s4_in.side.v2  = s3_v2_ff;
      s4_in.side.n1x = neg1 ^ s3_sgx_ff;
      s4_in.side.n1y = neg1 ^ s3_sgy_ff;
      s4_in.side.n2x = neg2 ^ s3_sgx_ff;
      s4_in.side.n2y = neg2 ^ s3_sgy_ff;
      s4_in.l2 = l2_ff;
      // root 0 means t = -1: p = l2, q = -l2
      s4_in.rx.p   = AccBits'(l2_ff);
      s4_in.rx.q   = -AccBits'(l2_ff);
      s4_in.rx.rhs = AccBits'(rx_ff);
      s4_in.rx.r   = '0;
      s4_in.ry.p   = AccBits'(l2_ff);
      s4_in.ry.q   = -AccBits'(l2_ff);
      s4_in.ry.rhs = AccBits'(ry_ff);
      s4_in.ry.r   = '0;
   end

   assign out_valid = s4_v_ff;
   assign out_stage = s4_ff;

endmodule

@@ src/dad_step.sv @@
// ----------------------------------------------------------------------------
// dad_step
// one bit of the rounded unit-magnitude search for both axes, registered
// ----------------------------------------------------------------------------
module dad_step #(
   parameter int K = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  dad_pkg::stage_type in_stage,
   output logic               out_valid,
   output dad_pkg::stage_type out_stage
);
   import dad_pkg::*;

   logic      v_ff;
   stage_type st_ff, st_in;

   function automatic root_type try_bit(input root_type s, input logic [L2Bits-1:0] l2);
      logic signed [AccBits-1:0] lw, cand;
      root_type o;
      lw   = AccBits'(l2);
      cand = s.p + (s.q <<< (K + 2)) + (lw <<< (2 * K + 2));
      o = s;
      if (cand <= s.rhs) begin
         o.p = cand;
         o.q = s.q + (lw <<< (K + 1));
         o.r = s.r | (RootBits'(1) << K);
      end
      try_bit = o;
   endfunction

   always_comb begin
      st_in    = in_stage;
      st_in.rx = try_bit(in_stage.rx, in_stage.l2);
      st_in.ry = try_bit(in_stage.ry, in_stage.l2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (en) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = v_ff;
   assign out_stage = st_ff;

endmodule

@@ src/dimension_arrow_direction_core.sv @@
// ----------------------------------------------------------------------------
// dimension_arrow_direction_core
// unit directions of dimension line arrows, fully pipelined
// ----------------------------------------------------------------------------
// req_ carries a line (start, end), two arrow positions and two arrow codes;
// rsp_ returns Q1.14 directions, a valid bit per arrow and a status.
// Both channels use valid/ready; a transfer happens when both are high.
// From a req_ transfer to rsp_valid an item passes through four front stages
// (differences, squares, sums, nearer arrow), fifteen search stages, one
// per bit of the rounded magnitude, and the output register.
// Throughput is one item per cycle unless stalled; every stage holds one item.
// When rsp_ready is low with a result waiting, the whole pipeline holds
// and req_ready drops; nothing is lost or repeated.
// Reset clears all stage valid bits; the block is ready right after.
// ----------------------------------------------------------------------------
`include "dimension_arrow_direction_core_assert.svh"

module dimension_arrow_direction_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_line_start_x,
   input  logic signed [31:0] req_line_start_y,
   input  logic signed [31:0] req_line_end_x,
   input  logic signed [31:0] req_line_end_y,
   input  logic signed [31:0] req_first_arrow_x,
   input  logic signed [31:0] req_first_arrow_y,
   input  logic signed [31:0] req_second_arrow_x,
   input  logic signed [31:0] req_second_arrow_y,
   input  logic [1:0]         req_first_arrow_code,
   input  logic [1:0]         req_second_arrow_code,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_first_dir_x,
   output logic signed [15:0] rsp_first_dir_y,
   output logic signed [15:0] rsp_second_dir_x,
   output logic signed [15:0] rsp_second_dir_y,
   output logic               rsp_first_dir_valid,
   output logic               rsp_second_dir_valid,
   output logic [1:0]         rsp_status
);
   import dad_pkg::*;

   logic      en;
   logic      sv [RootBits+1];
   stage_type ss [RootBits+1];
   stage_type last;

   logic               rsp_valid_ff;
   logic signed [15:0] d1x_ff, d1y_ff, d2x_ff, d2y_ff;
   logic               v1_ff, v2_ff;
   logic [1:0]         st_ff;

   function automatic logic [15:0] dir_of(input logic [RootBits-1:0] r,
                                          input logic neg, input logic keep);
      logic [15:0] m;
      m = 16'(r);
      dir_of = keep ? (neg ? -m : m) : 16'd0;
   endfunction

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   dad_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .sx        (req_line_start_x),
      .sy        (req_line_start_y),
      .ex        (req_line_end_x),
      .ey        (req_line_end_y),
      .p1x       (req_first_arrow_x),
      .p1y       (req_first_arrow_y),
      .p2x       (req_second_arrow_x),
      .p2y       (req_second_arrow_y),
      .c1        (req_first_arrow_code),
      .c2        (req_second_arrow_code),
      .out_valid (sv[0]),
      .out_stage (ss[0])
   );

   for (genvar i = 0; i < RootBits; i++) begin : g_step
      dad_step #(.K(RootBits - 1 - i)) u_step (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (sv[i]),
         .in_stage  (ss[i]),
         .out_valid (sv[i+1]),
         .out_stage (ss[i+1])
      );
   end

   assign last = ss[RootBits];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sv[RootBits];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1x_ff <= dir_of(last.rx.r, last.side.n1x, last.side.v1);
         d1y_ff <= dir_of(last.ry.r, last.side.n1y, last.side.v1);
         d2x_ff <= dir_of(last.rx.r, last.side.n2x, last.side.v2);
         d2y_ff <= dir_of(last.ry.r, last.side.n2y, last.side.v2);
         v1_ff  <= last.side.v1;
         v2_ff  <= last.side.v2;
         st_ff  <= last.side.status;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_first_dir_x      = d1x_ff;
   assign rsp_first_dir_y      = d1y_ff;
   assign rsp_second_dir_x     = d2x_ff;
   assign rsp_second_dir_y     = d2y_ff;
   assign rsp_first_dir_valid  = v1_ff;
   assign rsp_second_dir_valid = v2_ff;
   assign rsp_status           = st_ff;

   `DAD_ASSERT(a_err_no_dir, clock, reset, rsp_valid && rsp_status != ST_OK |-> !rsp_first_dir_valid && !rsp_second_dir_valid)
   `DAD_ASSERT(a_absent_zero, clock, reset, rsp_valid && !rsp_first_dir_valid |-> rsp_first_dir_x == 16'sd0 && rsp_first_dir_y == 16'sd0)
   `DAD_ASSERT(a_same_mag, clock, reset, rsp_valid && rsp_first_dir_valid && rsp_second_dir_valid |-> (rsp_first_dir_x == rsp_second_dir_x || rsp_first_dir_x == -rsp_second_dir_x))
   `DAD_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid)

endmodule

@@ verif/dimension_arrow_direction_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dimension_arrow_direction_core_test
// checks arrow directions and status against a local predictor, with random
// sender bursts and receiver stalls on both valid/ready channels
// ----------------------------------------------------------------------------
module dimension_arrow_direction_core_test;
   import dad_pkg::*;

   typedef struct {
      logic signed [31:0] sx, sy, ex, ey, ax, ay, bx, by;
      logic [1:0]         c1, c2;
   } line_item_type;

   typedef struct {
      logic signed [15:0] d1x, d1y, d2x, d2y;
      logic               v1, v2;
      logic [1:0]         st;
   } arrow_dirs_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_line_start_x = '0, req_line_start_y = '0;
   logic signed [31:0] req_line_end_x = '0, req_line_end_y = '0;
   logic signed [31:0] req_first_arrow_x = '0, req_first_arrow_y = '0;
   logic signed [31:0] req_second_arrow_x = '0, req_second_arrow_y = '0;
   logic [1:0] req_first_arrow_code = CODE_ABSENT, req_second_arrow_code = CODE_ABSENT;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [15:0] rsp_first_dir_x, rsp_first_dir_y, rsp_second_dir_x, rsp_second_dir_y;
   logic rsp_first_dir_valid, rsp_second_dir_valid;
   logic [1:0] rsp_status;

   dimension_arrow_direction_core dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   line_item_type  pending_lines[$];
   arrow_dirs_type expected_dirs[$];
   int errors = 0;
   int sent = 0, received = 0, idle_cycles = 0;
   int burst_left = 0, gap_left = 0;
   bit hold_send = 1'b0;
   bit all_queued = 1'b0;

   // rounded 16384*c/sqrt(l2), exact binary search
   function automatic logic [15:0] unit_component(logic [63:0] c, logic [63:0] l2);
      logic [127:0] rhs, lhs;
      logic [63:0]  lo, hi, mid, t;
      lo = 0;
      hi = 16384;
      rhs = {64'd0, c * c} << 30;
      while (lo < hi) begin
         mid = (lo + hi + 1) >> 1;
         t = 2 * mid - 1;
         lhs = {64'd0, t * t} * {64'd0, l2};
         if (lhs <= rhs) lo = mid;
         else hi = mid - 1;
      end
      return lo[15:0];
   endfunction

   function automatic logic [64:0] dist_sq(logic signed [31:0] px, logic signed [31:0] py,
                                           logic signed [31:0] qx, logic signed [31:0] qy);
      logic signed [32:0] dx, dy;
      logic [63:0] mx, my;
      dx = 33'(px) - 33'(qx);
      dy = 33'(py) - 33'(qy);
      mx = dx < 0 ? 64'(-dx) : 64'(dx);
      my = dy < 0 ? 64'(-dy) : 64'(dy);
      return {1'b0, mx * mx} + {1'b0, my * my};
   endfunction

   function automatic arrow_dirs_type predict_dirs(line_item_type it);
      arrow_dirs_type r;
      logic signed [32:0] dx, dy;
      logic [63:0] mx, my, l2;
      logic [15:0] ux, uy;
      bit near1, neg1, neg2;
      r = '{default: '0};
      if (it.c1 == CODE_INVALID || it.c2 == CODE_INVALID) begin
         r.st = ST_BAD_CODE;
         return r;
      end
      if (it.c1 == CODE_ABSENT && it.c2 == CODE_ABSENT) return r;
      if (it.sx == it.ex && it.sy == it.ey) begin
         r.st = ST_ZERO_LEN;
         return r;
      end
      dx = 33'(it.ex) - 33'(it.sx);
      dy = 33'(it.ey) - 33'(it.sy);
      mx = dx < 0 ? 64'(-dx) : 64'(dx);
      my = dy < 0 ? 64'(-dy) : 64'(dy);
      if (mx >= 64'h8000_0000 || my >= 64'h8000_0000) begin
         mx = mx >> 1;
         my = my >> 1;
      end
      l2 = mx * mx + my * my;
      ux = unit_component(mx, l2);
      uy = unit_component(my, l2);
      near1 = 1'b1;
      if (it.c1 != CODE_ABSENT && it.c2 != CODE_ABSENT)
         near1 = dist_sq(it.ax, it.ay, it.sx, it.sy) <= dist_sq(it.bx, it.by, it.sx, it.sy);
      neg1 = near1 ? (it.c1 == CODE_OUTWARD) : (it.c1 == CODE_INWARD);
      neg2 = near1 ? (it.c2 == CODE_INWARD) : (it.c2 == CODE_OUTWARD);
      if (it.c1 != CODE_ABSENT) begin
         r.d1x = (neg1 != (dx < 0)) ? -ux : ux;
         r.d1y = (neg1 != (dy < 0)) ? -uy : uy;
         r.v1 = 1'b1;
      end
      if (it.c2 != CODE_ABSENT) begin
         r.d2x = (neg2 != (dx < 0)) ? -ux : ux;
         r.d2y = (neg2 != (dy < 0)) ? -uy : uy;
         r.v2 = 1'b1;
      end
      return r;
   endfunction

   function automatic logic signed [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
         2: return 32'($signed($urandom_range(0, 64))) - 32;
         default: return 32'($signed($urandom_range(0, 32'h0010_0000))) - 32'sh0008_0000;
      endcase
   endfunction

   function automatic logic [1:0] rand_code();
      return $urandom_range(0, 9) == 0 ? CODE_INVALID : 2'($urandom_range(0, 2));
   endfunction

   task automatic queue_line(logic signed [31:0] sx, sy, ex, ey, ax, ay, bx, by,
                             logic [1:0] c1, c2);
      line_item_type it;
      it = '{sx, sy, ex, ey, ax, ay, bx, by, c1, c2};
      pending_lines.push_back(it);
   endtask

   // sender with random bursts and gaps
   always @(posedge clock) begin
      line_item_type it;
      if (!reset) begin
         if (req_valid && req_ready) begin
            it = pending_lines.pop_front();
            expected_dirs.push_back(predict_dirs(it));
            sent++;
         end
         if (!(req_valid && !req_ready)) begin
            if (gap_left > 0) gap_left--;
            if (pending_lines.size() > (req_valid && req_ready ? 0 : 0) && !hold_send
                && gap_left == 0 && !(req_valid && req_ready && pending_lines.size() == 0)) begin
               it = pending_lines[0];
               req_valid <= 1'b1;
               {req_line_start_x, req_line_start_y, req_line_end_x, req_line_end_y}
                  <= {it.sx, it.sy, it.ex, it.ey};
               {req_first_arrow_x, req_first_arrow_y, req_second_arrow_x, req_second_arrow_y}
                  <= {it.ax, it.ay, it.bx, it.by};
               req_first_arrow_code <= it.c1;
               req_second_arrow_code <= it.c2;
               if (burst_left > 0) burst_left--;
               else begin
                  burst_left = $urandom_range(0, 30);
                  gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern and checks
   always @(posedge clock) begin
      arrow_dirs_type e;
      if (!reset) begin
         rsp_ready <= ($urandom_range(0, 199) < 100) ? 1'b1 : ($urandom_range(0, 3) != 0);
         if (rsp_valid && rsp_ready) begin
            received++;
            if (expected_dirs.size() == 0) begin
               errors++;
               $display("%0t unexpected result, expected none, actual status %0d", $time,
                        rsp_status);
            end else begin
               e = expected_dirs.pop_front();
               if ({rsp_first_dir_x, rsp_first_dir_y, rsp_second_dir_x, rsp_second_dir_y,
                    rsp_first_dir_valid, rsp_second_dir_valid, rsp_status} !==
                   {e.d1x, e.d1y, e.d2x, e.d2y, e.v1, e.v2, e.st}) begin
                  errors++;
                  $display({"%0t mismatch expected %0d %0d %0d %0d v%0b%0b st%0d",
                            " actual %0d %0d %0d %0d v%0b%0b st%0d"},
                           $time, e.d1x, e.d1y, e.d2x, e.d2y, e.v1, e.v2, e.st,
                           rsp_first_dir_x, rsp_first_dir_y, rsp_second_dir_x,
                           rsp_second_dir_y, rsp_first_dir_valid, rsp_second_dir_valid,
                           rsp_status);
               end
            end
         end
      end
   end

   // watchdog on transfer activity
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      logic signed [31:0] sx, sy, ex, ey;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      queue_line(0, 0, 32'sh10000, 0, 0, 0, 32'sh10000, 0, CODE_INWARD, CODE_INWARD);
      queue_line(0, 0, 32'sh10000, 0, 32'sh10000, 0, 0, 0, CODE_OUTWARD, CODE_INWARD);
      queue_line(0, 0, 0, 32'sh10000, 5, 5, 5, 5, CODE_OUTWARD, CODE_OUTWARD);
      queue_line(0, 0, 3, 4, 0, 0, 0, 0, CODE_INWARD, CODE_ABSENT);
      queue_line(0, 0, -3, -4, 0, 0, 0, 0, CODE_ABSENT, CODE_OUTWARD);
      queue_line(1, 1, 1, 1, 0, 0, 0, 0, CODE_INWARD, CODE_ABSENT);
      queue_line(1, 1, 9, 1, 0, 0, 0, 0, CODE_ABSENT, CODE_ABSENT);
      queue_line(1, 1, 1, 1, 0, 0, 0, 0, CODE_ABSENT, CODE_ABSENT);
      queue_line(0, 0, 1, 1, 0, 0, 0, 0, CODE_INVALID, CODE_INWARD);
      queue_line(0, 0, 1, 1, 0, 0, 0, 0, CODE_ABSENT, CODE_INVALID);
      queue_line(32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff,
                 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                 CODE_INWARD, CODE_OUTWARD);
      queue_line(32'sh7fff_ffff, 0, 32'sh8000_0000, 1, 32'sh8000_0000, 32'sh8000_0000,
                 32'sh7fff_ffff, 32'sh7fff_ffff, CODE_OUTWARD, CODE_INWARD);
      queue_line(0, 32'sh8000_0000, 1, 32'sh7fff_ffff, 0, 0, -1, -1, CODE_INWARD, CODE_INWARD);
      queue_line(-1, -1, 0, 0, 32'sh7fff_ffff, -1, -1, 32'sh7fff_ffff,
                 CODE_OUTWARD, CODE_OUTWARD);
      wait (pending_lines.size() == 0 && expected_dirs.size() == 0 && !req_valid);
      @(posedge clock);
      hold_send = 1'b1;
      repeat (30) @(posedge clock);
      hold_send = 1'b0;

      // random: mostly short well-formed lines with arrows near each end
      repeat (1600) begin
         sx = rand_coord();
         sy = rand_coord();
         if ($urandom_range(0, 3) == 0) begin
            ex = rand_coord();
            ey = rand_coord();
         end else begin
            ex = sx + 32'($signed($urandom_range(0, 2000))) - 1000;
            ey = sy + 32'($signed($urandom_range(0, 2000))) - 1000;
         end
         if ($urandom_range(0, 3) == 0)
            queue_line(sx, sy, ex, ey, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_code(), rand_code());
         else
            queue_line(sx, sy, ex, ey, sx + 32'($urandom_range(0, 3)) - 1, sy,
                       ex, ey + 32'($urandom_range(0, 3)) - 1, rand_code(), rand_code());
         if (pending_lines.size() > 64) wait (pending_lines.size() < 32);
      end
      wait (pending_lines.size() == 0 && !req_valid);
      wait (expected_dirs.size() == 0);
      repeat (40) @(posedge clock);
      $display("sent %0d line items and checked %0d direction results", sent, received);
      $display("covered all arrow codes, zero-length lines and full-range coordinates");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
